[hw/rtl/kpdb_pkg.sv]
// ----------------------------------------------------------------------------
// kpdb_pkg
// Shared types and codes for the per-key press debounce filter.
// ----------------------------------------------------------------------------
package kpdb_pkg;

	localparam logic [4:0]         TYPE_SYNC      = 5'd0;
	localparam logic [4:0]         TYPE_KEY       = 5'd1;
	localparam logic [15:0]        SYNC_REPORT    = 16'd0;
	localparam logic [15:0]        SYNC_OVERFLOW  = 16'd3;
	localparam logic signed [31:0] KEY_UP         = 32'sd0;
	localparam logic signed [31:0] KEY_DOWN       = 32'sd1;
	localparam logic [15:0]        DEBOUNCE_RESET = 16'd75;

	// Outcome of one event, handed from the decision logic to the pipeline.
	typedef struct packed {
		logic fwd;       // event is passed on
		logic resync;    // drop mode ends on this event
		logic drop_nxt;  // drop mode after this event
		logic wr_en;     // key entry is updated
		logic wr_set;    // new press-valid bit of the entry
	} kpdb_decision_t;

endpackage

[hw/rtl/kpdb_key_mem.sv]
// ----------------------------------------------------------------------------
// kpdb_key_mem
// Per-key store of press-valid bit and press time, with a clearing pass after
// reset and a bypass for a write that lands on the entry being read.
// ----------------------------------------------------------------------------
module kpdb_key_mem #(
	parameter int NUM_KEYS  = 768,
	parameter int TIME_BITS = 32,
	parameter int IDX_W     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_idx,
	output logic [TIME_BITS:0]   rd_data,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_idx,
	input  logic [TIME_BITS:0]   wr_data,
	output logic                 clr_busy
);

	logic [TIME_BITS:0] mem_q [NUM_KEYS];
	logic [TIME_BITS:0] rd_q;
	logic [TIME_BITS:0] byp_q;
	logic               hit_q;
	logic               clr_busy_q;
	logic [IDX_W-1:0]   clr_idx_q;

	// The clearing pass walks every entry once, writing a cleared valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == IDX_W'(NUM_KEYS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q  <= mem_q[rd_idx];
			byp_q <= wr_data;
		end
	end

	// A write at the same edge as the read would otherwise return stale data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (rd_en) begin
			hit_q <= wr_en && (wr_idx == rd_idx);
		end
	end

	assign rd_data  = hit_q ? byp_q : rd_q;
	assign clr_busy = clr_busy_q;

endmodule

[hw/rtl/kpdb_decide.sv]
// ----------------------------------------------------------------------------
// kpdb_decide
// Per-event decision: drop mode, overflow and report handling, and the
// debounce test of a key-down against the key's last accepted press.
// ----------------------------------------------------------------------------
module kpdb_decide #(
	parameter int NUM_KEYS  = 768,
	parameter int TIME_BITS = 32
) (
	input  logic                    dropping,
	input  logic [4:0]              ev_type,
	input  logic [15:0]             ev_code,
	input  logic signed [31:0]      ev_value,
	input  logic [TIME_BITS-1:0]    now,
	input  logic                    entry_valid,
	input  logic [TIME_BITS-1:0]    entry_time,
	input  logic [15:0]             debounce,
	output kpdb_pkg::kpdb_decision_t dec
);

	logic [TIME_BITS-1:0] elapsed;
	logic                 in_range;
	logic                 too_soon;
	logic                 is_sync;

	assign elapsed  = now - entry_time;
	assign in_range = ev_code < 16'(NUM_KEYS);
	assign too_soon = entry_valid && (elapsed < TIME_BITS'(debounce));
	assign is_sync  = ev_type == kpdb_pkg::TYPE_SYNC;

	always_comb begin
		dec          = '0;
		dec.fwd      = 1'b1;
		dec.drop_nxt = dropping;
		priority if (dropping) begin
			dec.fwd = 1'b0;
			if (is_sync && ev_code == kpdb_pkg::SYNC_REPORT) begin
				dec.drop_nxt = 1'b0;
				dec.resync   = 1'b1;
			end
		end else if (is_sync && ev_code == kpdb_pkg::SYNC_OVERFLOW) begin
			dec.drop_nxt = 1'b1;
			dec.fwd      = 1'b0;
		end else if (ev_type == kpdb_pkg::TYPE_KEY) begin
			priority if (ev_value == kpdb_pkg::KEY_DOWN) begin
				if (in_range) begin
					if (too_soon) begin
						dec.fwd = 1'b0;
					end else begin
						dec.wr_en  = 1'b1;
						dec.wr_set = 1'b1;
					end
				end
			end else if (ev_value == kpdb_pkg::KEY_UP && in_range) begin
				dec.wr_en = 1'b1;
			end else begin
				dec.wr_en = 1'b0;
			end
		end else begin
			dec.fwd = 1'b1;
		end
	end

endmodule

[hw/rtl/key_press_debounce_filter_top.sv]
// ----------------------------------------------------------------------------
// key_press_debounce_filter_top
// Per-key press debounce filter for an input-event stream.
// ----------------------------------------------------------------------------
// Input events arrive on the in_valid/in_stall channel; each one yields exactly
// one result on the out_valid/out_stall channel, with forward telling whether
// the event is passed on and resync_request marking the report that ends drop
// mode. Type, code and value are copied to the result in every case.
// The key store is read at the input transfer, when the event enters the
// decision stage register; the decision is made there and loaded into the
// result register. Throughput is one event per cycle while out_stall is low;
// the single read port and single write port of the key store set it, with a
// bypass covering back-to-back events on the same key.
// After reset the key store is cleared one entry per cycle with in_stall high;
// the debounce threshold resets to 75 ms and may be written through
// cfg_valid/cfg_ready at any time, ready being always high. When the receiver
// stalls, the result holds, one more event may enter the decision stage, and
// then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module key_press_debounce_filter_top #(
	parameter int NUM_KEYS  = 768,
	parameter int TIME_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        debounce_ticks,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         event_type,
	input  logic [15:0]        event_code,
	input  logic signed [31:0] event_value,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               forward,
	output logic [4:0]         out_type,
	output logic [15:0]        out_code,
	output logic signed [31:0] out_value,
	output logic               resync_request
);

	localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	logic [15:0]               debounce_q;
	logic                      dropping_q;

	logic                      valid_s1;
	logic [4:0]                type_s1;
	logic [15:0]               code_s1;
	logic signed [31:0]        value_s1;
	logic [TIME_BITS-1:0]      now_s1;
	logic [TIME_BITS:0]        entry_s1;

	logic                      out_valid_q;
	logic                      forward_q;
	logic [4:0]                out_type_q;
	logic [15:0]               out_code_q;
	logic signed [31:0]        out_value_q;
	logic                      resync_q;

	logic                      clr_busy;
	logic                      load_out;
	logic                      adv;
	logic                      accept;
	logic                      mem_wr_en;
	kpdb_pkg::kpdb_decision_t  dec;

	assign load_out  = !out_valid_q || !out_stall;
	assign adv       = valid_s1 && load_out;
	assign in_stall  = clr_busy || (valid_s1 && !load_out);
	assign accept    = in_valid && !in_stall;
	assign mem_wr_en = adv && dec.wr_en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= kpdb_pkg::DEBOUNCE_RESET;
		end else if (cfg_valid) begin
			debounce_q <= debounce_ticks;
		end
	end

	kpdb_key_mem #(
		.NUM_KEYS  (NUM_KEYS),
		.TIME_BITS (TIME_BITS),
		.IDX_W     (IDX_W)
	) u_key_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx   (event_code[IDX_W-1:0]),
		.rd_data  (entry_s1),
		.wr_en    (mem_wr_en),
		.wr_idx   (code_s1[IDX_W-1:0]),
		.wr_data  ({dec.wr_set, now_s1}),
		.clr_busy (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1  <= event_type;
			code_s1  <= event_code;
			value_s1 <= event_value;
			now_s1   <= TIME_BITS'(now_ms);
		end
	end

	kpdb_decide #(
		.NUM_KEYS  (NUM_KEYS),
		.TIME_BITS (TIME_BITS)
	) u_decide (
		.dropping    (dropping_q),
		.ev_type     (type_s1),
		.ev_code     (code_s1),
		.ev_value    (value_s1),
		.now         (now_s1),
		.entry_valid (entry_s1[TIME_BITS]),
		.entry_time  (entry_s1[TIME_BITS-1:0]),
		.debounce    (debounce_q),
		.dec         (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropping_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				dropping_q <= dec.drop_nxt;
			end
			if (load_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			forward_q   <= dec.fwd;
			resync_q    <= dec.resync;
			out_type_q  <= type_s1;
			out_code_q  <= code_s1;
			out_value_q <= value_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign forward        = forward_q;
	assign out_type       = out_type_q;
	assign out_code       = out_code_q;
	assign out_value      = out_value_q;
	assign resync_request = resync_q;

	// A report that ends drop mode is never forwarded.
	a_resync_not_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(forward_q && resync_q))
		else $error("resync raised on a forwarded event");

	// The key store is not updated while it is being cleared.
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !mem_wr_en)
		else $error("key store written during clearing pass");

	// An overflow event enters drop mode.
	a_overflow_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !dropping_q && type_s1 == kpdb_pkg::TYPE_SYNC
			&& code_s1 == kpdb_pkg::SYNC_OVERFLOW) |=> dropping_q)
		else $error("overflow did not start drop mode");

	// Every event that passes through while dropping is suppressed.
	a_drop_suppresses: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dropping_q) |=> (out_valid_q && !forward_q))
		else $error("event forwarded in drop mode");

endmodule

[sim/tb_key_press_debounce_filter_top.sv]
// ----------------------------------------------------------------------------
// tb_key_press_debounce_filter_top
// Self-checking bench for the per-key press debounce filter.
// ----------------------------------------------------------------------------
// Each event that the filter accepts also goes through a behavioral model of
// the per-key press table and of drop mode kept here, and the result it should
// produce is queued. A monitor compares every result transfer, field by field,
// with the oldest queued result. Directed tests cover the field extremes, the
// debounce window, timestamp wrap, drop mode and the threshold extremes. Random
// traffic then runs under several idling patterns on both channels, and one
// long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb_key_press_debounce_filter_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                NUM_KEYS    = 768;
	localparam logic signed [31:0] KEY_REPEAT = 32'sd2;
	localparam int                HOT_KEYS    = 8;
	localparam int                HOLD_CYCLES = 200;
	localparam int                MAX_SHOWN   = 40;

	typedef struct packed {
		logic               fwd;
		logic [4:0]         etype;
		logic [15:0]        code;
		logic signed [31:0] value;
		logic               resync;
	} filter_result_t;

	logic               clk;
	logic               arst_n         = 1'b0;
	logic               cfg_valid      = 1'b0;
	logic               cfg_ready;
	logic [15:0]        debounce_ticks = '0;
	logic               in_valid       = 1'b0;
	logic               in_stall;
	logic [4:0]         event_type     = '0;
	logic [15:0]        event_code     = '0;
	logic signed [31:0] event_value    = '0;
	logic [31:0]        now_ms         = '0;
	logic               out_valid;
	logic               out_stall      = 1'b0;
	logic               forward;
	logic [4:0]         out_type;
	logic [15:0]        out_code;
	logic signed [31:0] out_value;
	logic               resync_request;

	// Model of the filter state.
	logic [31:0] press_time [NUM_KEYS];
	logic        press_seen [NUM_KEYS];
	logic        drop_mode;
	logic [15:0] threshold;

	filter_result_t pending_results [$];

	int          idle_pct  = 0;
	int          stall_pct = 0;
	logic        hold_start = 1'b0;
	int          hold_left  = 0;
	logic [31:0] ms_clock   = '0;
	logic [15:0] hot_keys [HOT_KEYS];

	int n_items      = 0;
	int n_results    = 0;
	int n_forwarded  = 0;
	int n_suppressed = 0;
	int n_bounces    = 0;
	int n_resyncs    = 0;
	int n_cfg        = 0;
	int n_stalled    = 0;
	int n_errors     = 0;

	key_press_debounce_filter_top #(
		.NUM_KEYS(NUM_KEYS),
		.TIME_BITS(32)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.debounce_ticks(debounce_ticks),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.event_type    (event_type),
		.event_code    (event_code),
		.event_value   (event_value),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.forward       (forward),
		.out_type      (out_type),
		.out_code      (out_code),
		.out_value     (out_value),
		.resync_request(resync_request)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Timeout with %0d results still pending.", pending_results.size());
		$display("tb_key_press_debounce_filter_top: done, errors");
		$finish;
	end

	// Receiver stall pattern; a requested hold-off overrides the random stalls.
	always @(posedge clk) begin
		if (hold_start) begin
			hold_left = HOLD_CYCLES;
			hold_start <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		if (n_errors <= MAX_SHOWN)
			$display("MISMATCH at result %0d: %s, got %0h, expected %0h",
				n_results, what, got, want);
	endtask

	always @(posedge clk) begin
		filter_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", out_code, '0);
			end else begin
				want = pending_results.pop_front();
				if (forward !== want.fwd)
					report_mismatch("forward", forward, want.fwd);
				if (out_type !== want.etype)
					report_mismatch("out_type", out_type, want.etype);
				if (out_code !== want.code)
					report_mismatch("out_code", out_code, want.code);
				if (out_value !== want.value)
					report_mismatch("out_value", out_value, want.value);
				if (resync_request !== want.resync)
					report_mismatch("resync_request", resync_request, want.resync);
			end
			n_results++;
		end
	end

	task automatic predict_filter(input logic [4:0] etype, input logic [15:0] code,
			input logic signed [31:0] value, input logic [31:0] t);
		filter_result_t r;
		logic [31:0]    elapsed;
		r = '{fwd: 1'b1, etype: etype, code: code, value: value, resync: 1'b0};
		if (drop_mode) begin
			r.fwd = 1'b0;
			if (etype == kpdb_pkg::TYPE_SYNC && code == kpdb_pkg::SYNC_REPORT) begin
				drop_mode = 1'b0;
				r.resync = 1'b1;
			end
		end else if (etype == kpdb_pkg::TYPE_SYNC && code == kpdb_pkg::SYNC_OVERFLOW) begin
			drop_mode = 1'b1;
			r.fwd = 1'b0;
		end else if (etype == kpdb_pkg::TYPE_KEY && code < NUM_KEYS) begin
			if (value == kpdb_pkg::KEY_DOWN) begin
				if (press_seen[code]) begin
					elapsed = t - press_time[code];
					if (elapsed < {16'd0, threshold}) begin
						r.fwd = 1'b0;
						n_bounces++;
					end
				end
				if (r.fwd) begin
					press_time[code] = t;
					press_seen[code] = 1'b1;
				end
			end else if (value == kpdb_pkg::KEY_UP) begin
				press_seen[code] = 1'b0;
			end
		end
		pending_results.push_back(r);
		n_items++;
		if (r.fwd)
			n_forwarded++;
		else
			n_suppressed++;
		if (r.resync)
			n_resyncs++;
	endtask

	// Offers one event and returns at the edge of its transfer. Valid stays high
	// on return so that back-to-back events need no second assignment per step.
	task automatic send_event(input logic [4:0] etype, input logic [15:0] code,
			input logic signed [31:0] value, input logic [31:0] t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		event_type  <= etype;
		event_code  <= code;
		event_value <= value;
		now_ms      <= t;
		do begin
			@(posedge clk);
			if (in_stall)
				n_stalled++;
		end while (in_stall);
		predict_filter(etype, code, value, t);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] ticks);
		wait_idle();
		cfg_valid      <= 1'b1;
		debounce_ticks <= ticks;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		threshold = ticks;
		n_cfg++;
	endtask

	// Mostly key traffic on a few hot keys with time steps around the
	// threshold, plus overflow bursts, stray sync codes and raw noise.
	task automatic send_random_event();
		int                 pick;
		int                 sub;
		logic signed [31:0] value;
		pick = $urandom_range(99);
		if ($urandom_range(199) == 0)
			ms_clock = $urandom;
		else
			ms_clock += $urandom_range(0, 2 * threshold + 4);
		if (pick < 60) begin
			sub = $urandom_range(9);
			value = (sub < 7) ? kpdb_pkg::KEY_DOWN : (sub < 9) ? kpdb_pkg::KEY_UP : KEY_REPEAT;
			send_event(kpdb_pkg::TYPE_KEY, hot_keys[$urandom_range(HOT_KEYS - 1)],
				value, ms_clock);
		end else if (pick < 68) begin
			send_event(kpdb_pkg::TYPE_KEY, 16'($urandom_range(NUM_KEYS, 65535)),
				$urandom_range(1) ? kpdb_pkg::KEY_DOWN : kpdb_pkg::KEY_UP, ms_clock);
		end else if (pick < 75) begin
			send_event(kpdb_pkg::TYPE_SYNC, kpdb_pkg::SYNC_OVERFLOW, $urandom, ms_clock);
			repeat ($urandom_range(0, 4))
				send_event(5'($urandom_range(0, 2)),
					hot_keys[$urandom_range(HOT_KEYS - 1)],
					kpdb_pkg::KEY_DOWN, ms_clock);
			// Now and then the report is missing and drop mode runs on.
			if ($urandom_range(9) != 0)
				send_event(kpdb_pkg::TYPE_SYNC, kpdb_pkg::SYNC_REPORT, $urandom,
					ms_clock);
		end else if (pick < 82) begin
			send_event(kpdb_pkg::TYPE_SYNC, 16'($urandom_range(0, 7)), $urandom, ms_clock);
		end else if (pick < 92) begin
			send_event(5'($urandom), 16'($urandom), $urandom, $urandom);
		end else begin
			send_event(kpdb_pkg::TYPE_KEY, 16'($urandom), $urandom, ms_clock);
		end
	endtask

	task automatic run_random_phase(input int items, input int sender_idle,
			input int receiver_stall, input logic [15:0] ticks);
		int stop_at;
		write_threshold(ticks);
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		hot_keys[0] = '0;
		hot_keys[1] = 16'(NUM_KEYS - 1);
		for (int i = 2; i < HOT_KEYS; i++)
			hot_keys[i] = 16'($urandom_range(NUM_KEYS - 1));
		stop_at = n_items + items;
		while (n_items < stop_at)
			send_random_event();
	endtask

	task automatic test_field_extremes();
		send_event(5'd31, 16'hFFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
		send_event(kpdb_pkg::TYPE_SYNC, 16'hFFFF, 32'h8000_0000, 32'd0);
		send_event(kpdb_pkg::TYPE_SYNC, 16'd2, 32'sd1, 32'd1);
		send_event(kpdb_pkg::TYPE_SYNC, kpdb_pkg::SYNC_REPORT, 32'sd0, 32'd2);
		send_event(kpdb_pkg::TYPE_KEY, 16'd0, kpdb_pkg::KEY_DOWN, 32'd0);
		send_event(kpdb_pkg::TYPE_KEY, 16'(NUM_KEYS - 1), kpdb_pkg::KEY_DOWN, 32'd0);
		send_event(kpdb_pkg::TYPE_KEY, 16'(NUM_KEYS), kpdb_pkg::KEY_DOWN, 32'd0);
		send_event(kpdb_pkg::TYPE_KEY, 16'hFFFF, kpdb_pkg::KEY_UP, 32'd0);
		send_event(kpdb_pkg::TYPE_KEY, 16'd0, KEY_REPEAT, 32'd5);
		send_event(kpdb_pkg::TYPE_KEY, 16'd0, 32'h8000_0000, 32'd6);
	endtask

	task automatic test_debounce_window();
		send_event(kpdb_pkg::TYPE_KEY, 16'd5, kpdb_pkg::KEY_DOWN, 32'd1000);
		send_event(kpdb_pkg::TYPE_KEY, 16'd5, kpdb_pkg::KEY_DOWN, 32'd1074);
		send_event(kpdb_pkg::TYPE_KEY, 16'd5, kpdb_pkg::KEY_DOWN, 32'd1075);
		send_event(kpdb_pkg::TYPE_KEY, 16'd5, kpdb_pkg::KEY_UP, 32'd1076);
		send_event(kpdb_pkg::TYPE_KEY, 16'd5, kpdb_pkg::KEY_DOWN, 32'd1077);
	endtask

	task automatic test_timestamp_wrap();
		send_event(kpdb_pkg::TYPE_KEY, 16'd9, kpdb_pkg::KEY_DOWN, 32'hFFFF_FFF0);
		send_event(kpdb_pkg::TYPE_KEY, 16'd9, kpdb_pkg::KEY_DOWN, 32'h0000_0010);
		send_event(kpdb_pkg::TYPE_KEY, 16'd9, kpdb_pkg::KEY_DOWN, 32'h0000_003B);
	endtask

	task automatic test_drop_mode();
		send_event(kpdb_pkg::TYPE_SYNC, kpdb_pkg::SYNC_OVERFLOW, 32'sd0, 32'd5000);
		send_event(kpdb_pkg::TYPE_KEY, 16'd20, kpdb_pkg::KEY_DOWN, 32'd5001);
		send_event(kpdb_pkg::TYPE_SYNC, kpdb_pkg::SYNC_OVERFLOW, 32'sd0, 32'd5002);
		send_event(5'd31, 16'd7, 32'sd3, 32'd5003);
		send_event(kpdb_pkg::TYPE_SYNC, kpdb_pkg::SYNC_REPORT, 32'sd0, 32'd5004);
		send_event(kpdb_pkg::TYPE_SYNC, kpdb_pkg::SYNC_REPORT, 32'sd0, 32'd5005);
		send_event(kpdb_pkg::TYPE_KEY, 16'd20, kpdb_pkg::KEY_DOWN, 32'd5006);
	endtask

	task automatic test_threshold_extremes();
		write_threshold(16'd0);
		send_event(kpdb_pkg::TYPE_KEY, 16'd30, kpdb_pkg::KEY_DOWN, 32'd7000);
		send_event(kpdb_pkg::TYPE_KEY, 16'd30, kpdb_pkg::KEY_DOWN, 32'd7000);
		write_threshold(16'hFFFF);
		send_event(kpdb_pkg::TYPE_KEY, 16'd31, kpdb_pkg::KEY_DOWN, 32'd8000);
		send_event(kpdb_pkg::TYPE_KEY, 16'd31, kpdb_pkg::KEY_DOWN, 32'd8000 + 32'd65534);
		send_event(kpdb_pkg::TYPE_KEY, 16'd31, kpdb_pkg::KEY_DOWN, 32'd8000 + 32'd65535);
		write_threshold(16'd1);
		send_event(kpdb_pkg::TYPE_KEY, 16'd32, kpdb_pkg::KEY_DOWN, 32'd100);
		send_event(kpdb_pkg::TYPE_KEY, 16'd32, kpdb_pkg::KEY_DOWN, 32'd100);
		send_event(kpdb_pkg::TYPE_KEY, 16'd32, kpdb_pkg::KEY_DOWN, 32'd101);
	endtask

	// The receiver holds off while events keep coming, so the block must fill
	// up and stall its input.
	task automatic test_backpressure();
		wait_idle();
		idle_pct   = 0;
		stall_pct  = 0;
		hold_start <= 1'b1;
		repeat (40)
			send_random_event();
	endtask

	task automatic test_random_traffic();
		run_random_phase(450, 0, 0, kpdb_pkg::DEBOUNCE_RESET);
		run_random_phase(450, 60, 0, 16'd20);
		run_random_phase(450, 0, 60, 16'd300);
		run_random_phase(450, 20, 20, 16'($urandom_range(1, 1000)));
	endtask

	initial begin
		for (int i = 0; i < NUM_KEYS; i++) begin
			press_time[i] = '0;
			press_seen[i] = 1'b0;
		end
		drop_mode = 1'b0;
		threshold = kpdb_pkg::DEBOUNCE_RESET;
		for (int i = 0; i < HOT_KEYS; i++)
			hot_keys[i] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 25;
		stall_pct = 25;
		test_field_extremes();
		test_debounce_window();
		test_timestamp_wrap();
		test_drop_mode();
		test_threshold_extremes();
		write_threshold(kpdb_pkg::DEBOUNCE_RESET);
		test_backpressure();
		test_random_traffic();

		wait_idle();
		repeat (10) @(posedge clk);
		$display("Ran %0d events: %0d passed on, %0d suppressed (%0d as bounces), %0d resyncs.",
			n_items, n_forwarded, n_suppressed, n_bounces, n_resyncs);
		$display("Threshold written %0d times; input held back for %0d cycles.",
			n_cfg, n_stalled);
		if (n_errors == 0)
			$display("tb_key_press_debounce_filter_top: done, clean");
		else
			$display("tb_key_press_debounce_filter_top: done, errors");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/kpdb_pkg.sv
hw/rtl/kpdb_key_mem.sv
hw/rtl/kpdb_decide.sv
hw/rtl/key_press_debounce_filter_top.sv
sim/tb_key_press_debounce_filter_top.sv
